### rtl/core/drlp_pkg.sv
package drlp_pkg;

    // accumulator width; numbers saturate at 2^NUM_W - 1
    localparam int NUM_W = 31;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // token queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // input command codes
    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_EOL  = 2'd1;
    localparam logic [1:0] CMD_EOF  = 2'd2;

    // record kind codes
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_DEL = 2'd1;
    localparam logic [1:0] KIND_CHG = 2'd2;
    localparam logic [1:0] KIND_ERR = 2'd3;

    // characters of the change command syntax
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_C     = 8'h63;

    // token types carried through the queue
    localparam logic [1:0] TOK_CHAR = 2'd0;
    localparam logic [1:0] TOK_EOL  = 2'd1;
    localparam logic [1:0] TOK_EOF  = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [30:0]        first_begin;
        logic signed [31:0] first_end;
        logic [30:0]        second_begin;
        logic signed [31:0] second_end;
        logic [1:0]         kind;
    } rec_t;

    typedef struct packed {
        logic [1:0] typ;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_comma;
        logic       is_kind;
        logic [1:0] kind;
    } tok_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
        tok_t tok;
    } q_head_t;

    typedef enum logic [7:0] {
        PH_FB   = 8'b0000_0001,
        PH_C1   = 8'b0000_0010,
        PH_FE   = 8'b0000_0100,
        PH_K    = 8'b0000_1000,
        PH_SB   = 8'b0001_0000,
        PH_C2   = 8'b0010_0000,
        PH_SE   = 8'b0100_0000,
        PH_STOP = 8'b1000_0000
    } phase_t;

endpackage

### rtl/core/drlp_front.sv
module drlp_front (
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  drlp_pkg::cmd_t cmd,
    input  logic           q_full,
    output logic           push,
    output drlp_pkg::tok_t push_tok
);

    logic accept;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;

    // unused command code is taken and dropped here
    assign push = accept && (cmd.command == drlp_pkg::CMD_CHAR ||
                             cmd.command == drlp_pkg::CMD_EOL  ||
                             cmd.command == drlp_pkg::CMD_EOF);

    always_comb
    begin
        push_tok.typ      = cmd.command;
        push_tok.is_digit = (cmd.ch >= drlp_pkg::CH_ZERO) && (cmd.ch <= drlp_pkg::CH_NINE);
        push_tok.digit    = 4'(cmd.ch - drlp_pkg::CH_ZERO);
        push_tok.is_comma = (cmd.ch == drlp_pkg::CH_COMMA);
        push_tok.is_kind  = 1'b1;
        push_tok.kind     = drlp_pkg::KIND_ADD;
        case (cmd.ch)
            drlp_pkg::CH_A: push_tok.kind = drlp_pkg::KIND_ADD;
            drlp_pkg::CH_D: push_tok.kind = drlp_pkg::KIND_DEL;
            drlp_pkg::CH_C: push_tok.kind = drlp_pkg::KIND_CHG;
            default:        push_tok.is_kind = 1'b0;
        endcase
        if (!push_tok.is_digit)
        begin
            push_tok.digit = 4'd0;
        end
    end

endmodule

### rtl/core/drlp_queue.sv
module drlp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  drlp_pkg::tok_t    push_tok,
    input  logic              pop,
    output drlp_pkg::q_head_t head
);

    drlp_pkg::tok_t                     slot_reg [drlp_pkg::QDEPTH];
    logic [drlp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [drlp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [drlp_pkg::QCNT_W-1:0]        count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == drlp_pkg::QPTR_W'(drlp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == drlp_pkg::QPTR_W'(drlp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.full  = (count_reg == drlp_pkg::QCNT_W'(drlp_pkg::QDEPTH));
    assign head.tok   = slot_reg[rd_ptr_reg];

endmodule

### rtl/core/drlp_back.sv
module drlp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  drlp_pkg::q_head_t head,
    output logic              pop,
    output logic              rec_valid,
    input  logic              rec_stall,
    output drlp_pkg::rec_t    rec
);

    drlp_pkg::phase_t             phase_reg, phase_next;
    logic [drlp_pkg::NUM_W-1:0]   nfb_reg, nfb_next;
    logic [drlp_pkg::NUM_W-1:0]   nfe_reg, nfe_next;
    logic [drlp_pkg::NUM_W-1:0]   nsb_reg, nsb_next;
    logic [drlp_pkg::NUM_W-1:0]   nse_reg, nse_next;
    logic [3:0]                   marks_reg, marks_next;
    logic [1:0]                   kind_reg, kind_next;
    logic                         kvalid_reg, kvalid_next;
    logic                         seen_reg, seen_next;
    logic                         made_reg, made_next;
    logic                         out_valid_reg, out_valid_next;
    drlp_pkg::rec_t               out_reg, out_next;

    logic                         out_ready;
    logic                         line_rec;
    logic                         emit;
    drlp_pkg::rec_t               line_out;
    drlp_pkg::tok_t               tok;
    logic [drlp_pkg::NUM_W-1:0]   acc_in;
    logic [drlp_pkg::NUM_W+3:0]   acc_wide;
    logic [drlp_pkg::NUM_W-1:0]   acc_out;

    assign tok       = head.tok;
    assign out_ready = !out_valid_reg || !rec_stall;
    assign pop       = head.valid && out_ready;

    // one shared x10 + digit accumulator, operand picked by phase
    always_comb
    begin
        case (phase_reg)
            drlp_pkg::PH_FB:                 acc_in = nfb_reg;
            drlp_pkg::PH_C1, drlp_pkg::PH_FE: acc_in = nfe_reg;
            drlp_pkg::PH_K, drlp_pkg::PH_SB:  acc_in = nsb_reg;
            default:                         acc_in = nse_reg;
        endcase
        acc_wide = ({4'd0, acc_in} << 3) + ({4'd0, acc_in} << 1) +
                   (drlp_pkg::NUM_W + 4)'(tok.digit);
        acc_out  = (acc_wide > {4'd0, drlp_pkg::NUM_MAX}) ?
                   drlp_pkg::NUM_MAX : acc_wide[drlp_pkg::NUM_W-1:0];
    end

    // record for the line held now
    always_comb
    begin
        line_rec              = marks_reg[0] && kvalid_reg && marks_reg[2];
        line_out.first_begin  = 31'(nfb_reg);
        line_out.first_end    = marks_reg[1] ? 32'(nfe_reg) : -32'sd1;
        line_out.second_begin = 31'(nsb_reg);
        line_out.second_end   = marks_reg[3] ? 32'(nse_reg) : -32'sd1;
        line_out.kind         = kind_reg;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        nfb_next       = nfb_reg;
        nfe_next       = nfe_reg;
        nsb_next       = nsb_reg;
        nse_next       = nse_reg;
        marks_next     = marks_reg;
        kind_next      = kind_reg;
        kvalid_next    = kvalid_reg;
        seen_next      = seen_reg;
        made_next      = made_reg;
        emit           = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (pop)
        begin
            case (tok.typ)
                drlp_pkg::TOK_CHAR:
                begin
                    seen_next = 1'b1;
                    case (phase_reg)
                        drlp_pkg::PH_FB:
                        begin
                            if (tok.is_digit)
                            begin
                                nfb_next      = acc_out;
                                marks_next[0] = 1'b1;
                            end
                            else if (marks_reg[0] && tok.is_comma)
                                phase_next = drlp_pkg::PH_C1;
                            else if (marks_reg[0] && tok.is_kind)
                            begin
                                kind_next   = tok.kind;
                                kvalid_next = 1'b1;
                                phase_next  = drlp_pkg::PH_K;
                            end
                            else
                                phase_next = drlp_pkg::PH_STOP;
                        end
                        drlp_pkg::PH_C1:
                        begin
                            if (tok.is_digit)
                            begin
                                nfe_next      = acc_out;
                                marks_next[1] = 1'b1;
                                phase_next    = drlp_pkg::PH_FE;
                            end
                            else
                                phase_next = drlp_pkg::PH_STOP;
                        end
                        drlp_pkg::PH_FE:
                        begin
                            if (tok.is_digit)
                                nfe_next = acc_out;
                            else if (tok.is_kind)
                            begin
                                kind_next   = tok.kind;
                                kvalid_next = 1'b1;
                                phase_next  = drlp_pkg::PH_K;
                            end
                            else
                                phase_next = drlp_pkg::PH_STOP;
                        end
                        drlp_pkg::PH_K:
                        begin
                            if (tok.is_digit)
                            begin
                                nsb_next      = acc_out;
                                marks_next[2] = 1'b1;
                                phase_next    = drlp_pkg::PH_SB;
                            end
                            else
                                phase_next = drlp_pkg::PH_STOP;
                        end
                        drlp_pkg::PH_SB:
                        begin
                            if (tok.is_digit)
                                nsb_next = acc_out;
                            else if (tok.is_comma)
                                phase_next = drlp_pkg::PH_C2;
                            else
                                phase_next = drlp_pkg::PH_STOP;
                        end
                        drlp_pkg::PH_C2:
                        begin
                            if (tok.is_digit)
                            begin
                                nse_next      = acc_out;
                                marks_next[3] = 1'b1;
                                phase_next    = drlp_pkg::PH_SE;
                            end
                            else
                                phase_next = drlp_pkg::PH_STOP;
                        end
                        drlp_pkg::PH_SE:
                        begin
                            if (!tok.is_digit)
                                phase_next = drlp_pkg::PH_STOP;
                            else
                                nse_next = acc_out;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                drlp_pkg::TOK_EOL, drlp_pkg::TOK_EOF:
                begin
                    // close the line
                    phase_next  = drlp_pkg::PH_FB;
                    nfb_next    = '0;
                    nfe_next    = '0;
                    nsb_next    = '0;
                    nse_next    = '0;
                    marks_next  = '0;
                    kind_next   = '0;
                    kvalid_next = 1'b0;
                    emit        = line_rec;
                    out_next    = line_out;
                    if (tok.typ == drlp_pkg::TOK_EOL)
                    begin
                        seen_next = 1'b1;
                        made_next = made_reg || line_rec;
                    end
                    else
                    begin
                        if (!line_rec && seen_reg && !made_reg)
                        begin
                            emit                  = 1'b1;
                            out_next.first_begin  = '0;
                            out_next.first_end    = '0;
                            out_next.second_begin = '0;
                            out_next.second_end   = '0;
                            out_next.kind         = drlp_pkg::KIND_ERR;
                        end
                        seen_next = 1'b0;
                        made_next = 1'b0;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (out_ready)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= drlp_pkg::PH_FB;
            nfb_reg       <= '0;
            nfe_reg       <= '0;
            nsb_reg       <= '0;
            nse_reg       <= '0;
            marks_reg     <= '0;
            kind_reg      <= '0;
            kvalid_reg    <= 1'b0;
            seen_reg      <= 1'b0;
            made_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nfb_reg       <= nfb_next;
            nfe_reg       <= nfe_next;
            nsb_reg       <= nsb_next;
            nse_reg       <= nse_next;
            marks_reg     <= marks_next;
            kind_reg      <= kind_next;
            kvalid_reg    <= kvalid_next;
            seen_reg      <= seen_next;
            made_reg      <= made_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;

endmodule

### rtl/core/diff_range_line_parser.sv
// channel | dir | handshake           | beat
// --------+-----+---------------------+------------------------------------
// cmd     | in  | cmd_valid/cmd_stall | command (char/eol/eof), ch
// rec     | out | rec_valid/rec_stall | first/second begin+end, kind
//
// One beat per cycle sustained while rec_stall stays low; a beat's record reaches rec
// after acceptance through the queue slot, then the output register.
// The parse FSM and shared x10 accumulator in the back end update once a cycle while a token is popped.
// rst_n is asynchronous: parser returns to line start, queue and output empty.
// cmd_stall rises only when the 4-entry token queue is full; the back end
// stalls on its own only while a record sits unaccepted in the output register.
module diff_range_line_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  drlp_pkg::cmd_t cmd,
    output logic           rec_valid,
    input  logic           rec_stall,
    output drlp_pkg::rec_t rec
);

    // front -> queue
    logic              push;
    drlp_pkg::tok_t    push_tok;
    // queue -> back
    drlp_pkg::q_head_t head;
    logic              pop;

    // front end: handshake and character classification
    drlp_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (head.full),
        .push      (push),
        .push_tok  (push_tok)
    );

    // short token queue decoupling the two halves
    drlp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .head     (head)
    );

    // back end: parse FSM, accumulators, record register
    drlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec)
    );

    // error record carries nothing but its kind
    a_err_rec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.kind == drlp_pkg::KIND_ERR |->
        rec.first_begin == '0 && rec.second_begin == '0 &&
        rec.first_end == '0 && rec.second_end == '0)
        else $error("error record with nonzero range");

    // ends are either absent (-1) or a saturated non-negative number
    a_end_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.kind != drlp_pkg::KIND_ERR |->
        (!rec.first_end[31] || rec.first_end == -32'sd1) &&
        (!rec.second_end[31] || rec.second_end == -32'sd1))
        else $error("record end out of range");

    // a full queue always presents a head to the back end
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        head.full |-> head.valid)
        else $error("queue full without valid head");

    // back end never drains the queue while its record is held
    a_no_pop_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_stall |-> !pop)
        else $error("token consumed while record stalled");

endmodule
